@@ hw/rtl/tlik_pkg.sv @@
// Shared types, constants and the arctangent table for the three link leg IK block.
// No dependencies; used by tlik_cordic, tlik_isqrt and the top level.
`timescale 1ns / 1ps
`default_nettype none
package tlik_pkg;

  localparam int CORDIC_STEPS_DEF = 16;

  localparam int LEN_W   = 14;              // link length registers
  localparam int COORD_W = 16;              // foot coordinates
  localparam int OUT_W   = 17;              // Q3.13 output angles
  localparam int ARG_W   = 34;              // CORDIC operand width
  localparam int ANG_W   = 34;              // Q2.29 angle width
  localparam int CW      = 44;              // CORDIC working width
  localparam int RAD_W   = 64;              // square root radicand
  localparam int ROOT_W  = 32;

  localparam logic signed [ANG_W-1:0] PI_Q29 = 34'sd1686629713;

  localparam logic [1:0] REG_HIP    = 2'd0;
  localparam logic [1:0] REG_THIGH  = 2'd1;
  localparam logic [1:0] REG_SHIN   = 2'd2;
  localparam logic [1:0] REG_MIRROR = 2'd3;

  // atan(2^-i) in Q2.29, rounded to nearest
  function automatic logic signed [ANG_W-1:0] atan_q29(input logic [4:0] idx);
    logic signed [ANG_W-1:0] v;
    case (idx)
      5'd0:  v = 34'sd421657428;
      5'd1:  v = 34'sd248918915;
      5'd2:  v = 34'sd131521918;
      5'd3:  v = 34'sd66762579;
      5'd4:  v = 34'sd33510843;
      5'd5:  v = 34'sd16771758;
      5'd6:  v = 34'sd8387925;
      5'd7:  v = 34'sd4194219;
      5'd8:  v = 34'sd2097141;
      5'd9:  v = 34'sd1048575;
      5'd10: v = 34'sd524288;
      5'd11: v = 34'sd262144;
      5'd12: v = 34'sd131072;
      5'd13: v = 34'sd65536;
      5'd14: v = 34'sd32768;
      5'd15: v = 34'sd16384;
      5'd16: v = 34'sd8192;
      5'd17: v = 34'sd4096;
      5'd18: v = 34'sd2048;
      5'd19: v = 34'sd1024;
      5'd20: v = 34'sd512;
      5'd21: v = 34'sd256;
      5'd22: v = 34'sd128;
      5'd23: v = 34'sd64;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/three_link_leg_inverse_kinematics.sv @@
// Three link leg inverse kinematics: sequencer, shared multiplier and result register.
// Depends on tlik_pkg, tlik_isqrt and tlik_cordic.
//
// Usage:
//   Input channel (in_valid/in_ready) carries func, coord_x, coord_y, coord_z.
//   func 0 sets the stored foot position, func 1 adds a saturating relative move.
//   Output channel (out_valid/out_ready) carries hip, knee and ankle angles in
//   Q3.13 radians and the out_of_reach flag, one result per input transaction.
//   Configuration: cfg_write with cfg_index/cfg_data sets the link lengths and
//   the mirror bit; write only while the block is idle.
//   Each transaction runs up to three passes of the bit-serial square root (one
//   skipped for each clamped acos) and four passes of the shared CORDIC, each
//   with its normalization shifts, plus multiplier and sequencing steps.
//   One transaction is in work at a time; in_ready is high only in idle.
//   A finished result waits in the output register; the next input transaction
//   is accepted while it waits, and the new result is held until out_ready.
//   Reset clears the foot position, the configuration and both channels.
`timescale 1ns / 1ps
`default_nettype none
module three_link_leg_inverse_kinematics #(
  parameter int CORDIC_STEPS = tlik_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [1:0]                          cfg_index,
  input  logic [tlik_pkg::LEN_W-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                func,
  input  logic signed [tlik_pkg::COORD_W-1:0] coord_x,
  input  logic signed [tlik_pkg::COORD_W-1:0] coord_y,
  input  logic signed [tlik_pkg::COORD_W-1:0] coord_z,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [tlik_pkg::OUT_W-1:0]   hip_angle,
  output logic signed [tlik_pkg::OUT_W-1:0]   knee_angle,
  output logic signed [tlik_pkg::OUT_W-1:0]   ankle_angle,
  output logic                                out_of_reach
);
  import tlik_pkg::*;

  typedef enum logic [17:0] {
    ST_IDLE      = 18'b1 << 0,
    ST_MUL_X     = 18'b1 << 1,
    ST_MUL_Y     = 18'b1 << 2,
    ST_MUL_M     = 18'b1 << 3,
    ST_MUL_L     = 18'b1 << 4,
    ST_RHO_WAIT  = 18'b1 << 5,
    ST_MUL_A     = 18'b1 << 6,
    ST_MUL_Z     = 18'b1 << 7,
    ST_SUM_C     = 18'b1 << 8,
    ST_MUL_CM    = 18'b1 << 9,
    ST_MUL_N     = 18'b1 << 10,
    ST_CHK       = 18'b1 << 11,
    ST_ROOT_S    = 18'b1 << 12,
    ST_CORD_ACOS = 18'b1 << 13,
    ST_CORD_KA   = 18'b1 << 14,
    ST_MUL_ML    = 18'b1 << 15,
    ST_CORD_HIP  = 18'b1 << 16,
    ST_FIN       = 18'b1 << 17
  } state_t;

  state_t state;

  logic [LEN_W-1:0]          hip_len, thigh_len, shin_len;
  logic                      mirror;
  logic signed [COORD_W-1:0] foot_x, foot_y, foot_z;

  logic [31:0]               sum_xy;
  logic [31:0]               c2;
  logic [27:0]               m2, l2;
  logic signed [17:0]        a_val;
  logic signed [ARG_W-1:0]   nval;
  logic [63:0]               prod, d2;
  logic [31:0]               mul_a, mul_b;
  logic                      mul_en;
  logic                      ankle_phase;
  logic                      reach_flag;
  logic signed [ANG_W-1:0]   acos_ang, knee_q, ankle_q, hip_q;
  logic                      load_out;

  logic                      sq_start, sq_done;
  logic [RAD_W-1:0]          sq_rad;
  logic [ROOT_W-1:0]         sq_root;
  logic                      cord_start, cord_done;
  logic signed [ARG_W-1:0]   cord_y, cord_x;
  logic signed [ANG_W-1:0]   cord_ang;
  logic                      d2_bad;

  function automatic logic signed [COORD_W-1:0] sat_add(
    input logic signed [COORD_W-1:0] p, input logic signed [COORD_W-1:0] q);
    logic signed [COORD_W:0] s;
    s = {p[COORD_W-1], p} + {q[COORD_W-1], q};
    if (s[COORD_W] != s[COORD_W-1]) return s[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}}
                                                      : {1'b0, {(COORD_W-1){1'b1}}};
    return s[COORD_W-1:0];
  endfunction

  function automatic logic [31:0] mag16(input logic signed [COORD_W-1:0] v);
    logic signed [COORD_W:0] e;
    e = {v[COORD_W-1], v};
    return 32'(e[COORD_W] ? -e : e);
  endfunction

  function automatic logic signed [OUT_W-1:0] round_q13(input logic signed [ANG_W-1:0] q);
    logic signed [ANG_W-1:0] t;
    t = q + 34'sd32768;
    return t[32:16];
  endfunction

  function automatic logic signed [ARG_W-1:0] ext16(input logic signed [COORD_W-1:0] v);
    return {{(ARG_W-COORD_W){v[COORD_W-1]}}, v};
  endfunction

  assign in_ready = (state == ST_IDLE);
  assign load_out = (state == ST_FIN) && (!out_valid || out_ready);
  assign d2_bad   = (d2 == '0) || (prod > d2);

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      hip_len   <= '0;
      thigh_len <= '0;
      shin_len  <= '0;
      mirror    <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_HIP:    hip_len   <= cfg_data;
        REG_THIGH:  thigh_len <= cfg_data;
        REG_SHIN:   shin_len  <= cfg_data;
        REG_MIRROR: mirror    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (state)
      ST_MUL_X: begin
        mul_a = mag16(foot_x);
        mul_b = mag16(foot_x);
      end
      ST_MUL_Y: begin
        mul_a = mag16(foot_y);
        mul_b = mag16(foot_y);
      end
      ST_MUL_M: begin
        mul_a = 32'(thigh_len);
        mul_b = 32'(thigh_len);
      end
      ST_MUL_L: begin
        mul_a = 32'(shin_len);
        mul_b = 32'(shin_len);
      end
      ST_MUL_A: begin
        mul_a = 32'(a_val[17] ? -a_val : a_val);
        mul_b = 32'(a_val[17] ? -a_val : a_val);
      end
      ST_MUL_Z: begin
        mul_a = mag16(foot_z);
        mul_b = mag16(foot_z);
      end
      ST_MUL_CM: begin
        mul_a = c2;
        mul_b = 32'(m2);
      end
      ST_MUL_N: begin
        mul_a = 32'(nval[ARG_W-1] ? -nval : nval);
        mul_b = 32'(nval[ARG_W-1] ? -nval : nval);
      end
      ST_MUL_ML: begin
        mul_a = 32'(m2);
        mul_b = 32'(l2);
      end
      default: mul_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mul_en) prod <= 64'(mul_a) * 64'(mul_b);
  end

  // unit start select
  always_comb begin
    sq_start   = 1'b0;
    sq_rad     = d2 - prod;
    cord_start = 1'b0;
    cord_y     = '0;
    cord_x     = nval;
    case (state)
      ST_MUL_L: begin
        sq_start = 1'b1;
        sq_rad   = {32'b0, sum_xy};
      end
      ST_CHK: begin
        sq_start   = !d2_bad;
        cord_start = d2_bad;
      end
      ST_ROOT_S: begin
        cord_start = sq_done;
        cord_y     = {2'b00, sq_root};
      end
      ST_CORD_ACOS: begin
        cord_start = cord_done;
        if (ankle_phase) begin
          cord_y = ext16(foot_x);
          cord_x = ext16(foot_y);
        end else begin
          cord_y = ext16(foot_z);
          cord_x = {{(ARG_W-18){a_val[17]}}, a_val};
        end
      end
      default: ;
    endcase
  end

  tlik_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (sq_rad),
    .done     (sq_done),
    .root     (sq_root)
  );

  tlik_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cord_start),
    .y_in  (cord_y),
    .x_in  (cord_x),
    .done  (cord_done),
    .angle (cord_ang)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      foot_x     <= '0;
      foot_y     <= '0;
      foot_z     <= '0;
      out_valid  <= 1'b0;
      reach_flag <= 1'b0;
      ankle_phase <= 1'b0;
    end else begin
      if (load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            if (func) begin
              foot_x <= sat_add(foot_x, coord_x);
              foot_y <= sat_add(foot_y, coord_y);
              foot_z <= sat_add(foot_z, coord_z);
            end else begin
              foot_x <= coord_x;
              foot_y <= coord_y;
              foot_z <= coord_z;
            end
            reach_flag  <= 1'b0;
            ankle_phase <= 1'b0;
            state <= ST_MUL_X;
          end
        end
        ST_MUL_X: state <= ST_MUL_Y;
        ST_MUL_Y: state <= ST_MUL_M;
        ST_MUL_M: state <= ST_MUL_L;
        ST_MUL_L: state <= ST_RHO_WAIT;
        ST_RHO_WAIT: if (sq_done) state <= ST_MUL_A;
        ST_MUL_A: state <= ST_MUL_Z;
        ST_MUL_Z: state <= ST_SUM_C;
        ST_SUM_C: state <= ST_MUL_CM;
        ST_MUL_CM: state <= ST_MUL_N;
        ST_MUL_N: state <= ST_CHK;
        ST_CHK: begin
          if (d2_bad) begin
            reach_flag <= 1'b1;
            state <= ST_CORD_ACOS;
          end else begin
            state <= ST_ROOT_S;
          end
        end
        ST_ROOT_S: if (sq_done) state <= ST_CORD_ACOS;
        ST_CORD_ACOS: begin
          if (cord_done) state <= ankle_phase ? ST_CORD_HIP : ST_CORD_KA;
        end
        ST_CORD_KA: if (cord_done) state <= ST_MUL_ML;
        ST_MUL_ML: begin
          ankle_phase <= 1'b1;
          state <= ST_MUL_N;
        end
        ST_CORD_HIP: if (cord_done) state <= ST_FIN;
        ST_FIN: if (load_out) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_MUL_Y: sum_xy <= prod[31:0];
      ST_MUL_M: sum_xy <= sum_xy + prod[31:0];
      ST_MUL_L: m2 <= prod[27:0];
      ST_RHO_WAIT: begin
        l2 <= prod[27:0];
        a_val <= {2'b00, sq_root[15:0]} - {4'b0000, hip_len};
      end
      ST_MUL_Z: c2 <= prod[31:0];
      ST_SUM_C: c2 <= c2 + prod[31:0];
      ST_MUL_CM: nval <= ARG_W'(c2) + ARG_W'(m2) - ARG_W'(l2);
      ST_MUL_N: d2 <= prod << 2;
      ST_MUL_ML: nval <= ARG_W'(m2) + ARG_W'(l2) - ARG_W'(c2);
      ST_CORD_ACOS: begin
        if (cord_done) begin
          if (ankle_phase) ankle_q <= cord_ang - PI_Q29;
          else acos_ang <= cord_ang;
        end
      end
      ST_CORD_KA: if (cord_done) knee_q <= acos_ang - cord_ang;
      ST_CORD_HIP: if (cord_done) hip_q <= mirror ? -cord_ang : cord_ang;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      hip_angle    <= round_q13(hip_q);
      knee_angle   <= round_q13(knee_q);
      ankle_angle  <= round_q13(ankle_q);
      out_of_reach <= reach_flag;
    end
  end

`ifndef SYNTHESIS
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load_out |-> (!out_valid || out_ready))
    else $error("result register overwritten while full");

  a_flag_clear: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (!reach_flag && state == ST_MUL_X))
    else $error("transaction start did not clear the reach flag");

  a_rose_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_FIN))
    else $error("result shown outside the finish step");

  a_unit_idle: assert property (@(posedge clk) disable iff (rst)
    cord_start |-> (state == ST_CHK || state == ST_ROOT_S || state == ST_CORD_ACOS))
    else $error("CORDIC started from an unexpected step");
`endif

endmodule
`default_nettype wire

@@ hw/rtl/tlik_isqrt.sv @@
// Iterative floor square root of a 64 bit value, one result bit per cycle.
// Depends on tlik_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tlik_isqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [tlik_pkg::RAD_W-1:0]  radicand,
  output logic                        done,
  output logic [tlik_pkg::ROOT_W-1:0] root
);
  import tlik_pkg::*;

  logic             busy;
  logic [4:0]       k;
  logic [RAD_W-1:0] v;
  logic [RAD_W-1:0] res;
  logic [RAD_W-1:0] bitv;
  logic [RAD_W-1:0] trial;

  assign bitv  = RAD_W'(1) << {k, 1'b0};
  assign trial = res + bitv;
  assign root  = res[ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && k == 5'd0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v   <= radicand;
      res <= '0;
      k   <= 5'd31;
    end else if (busy) begin
      if (v >= trial) begin
        v   <= v - trial;
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      k <= k - 5'd1;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/tlik_cordic.sv @@
// Iterative vectoring CORDIC giving atan2(y, x) in Q2.29, with pre-normalization.
// Depends on tlik_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tlik_cordic #(
  parameter int STEPS = tlik_pkg::CORDIC_STEPS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [tlik_pkg::ARG_W-1:0] y_in,
  input  logic signed [tlik_pkg::ARG_W-1:0] x_in,
  output logic                              done,
  output logic signed [tlik_pkg::ANG_W-1:0] angle
);
  import tlik_pkg::*;

  localparam int IW = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam logic [CW-1:0] NORM_LIMIT = CW'(1) << 39;
  localparam logic [CW-1:0] BYTE_LIMIT = CW'(1) << 31;

  typedef enum logic [2:0] {
    C_IDLE = 3'b001,
    C_NORM = 3'b010,
    C_ITER = 3'b100
  } cstate_t;

  cstate_t                 state;
  logic signed [CW-1:0]    xv, yv;
  logic signed [CW-1:0]    xs, ys;
  logic [CW-1:0]           ax, ay, mx;
  logic signed [CW-1:0]    dx, dy;
  logic signed [ANG_W-1:0] step_ang;
  logic [IW-1:0]           iter;

  assign xs = {{(CW-ARG_W){x_in[ARG_W-1]}}, x_in};
  assign ys = {{(CW-ARG_W){y_in[ARG_W-1]}}, y_in};
  assign ax = xv[CW-1] ? -xv : xv;
  assign ay = yv[CW-1] ? -yv : yv;
  assign mx = (ax > ay) ? ax : ay;
  assign dx = yv >>> iter;
  assign dy = xv >>> iter;
  assign step_ang = atan_q29(5'(iter));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        C_IDLE: begin
          if (start && !(x_in == '0 && y_in == '0)) state <= C_NORM;
          else if (start) done <= 1'b1;
        end
        C_NORM: begin
          if (mx >= NORM_LIMIT) state <= C_ITER;
        end
        C_ITER: begin
          if (iter == IW'(STEPS-1)) begin
            state <= C_IDLE;
            done  <= 1'b1;
          end
        end
        default: state <= C_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      C_IDLE: begin
        if (start) begin
          if (x_in == '0 && y_in == '0) begin
            angle <= '0;
          end else if (x_in[ARG_W-1]) begin
            angle <= y_in[ARG_W-1] ? -PI_Q29 : PI_Q29;
            xv    <= -xs;
            yv    <= -ys;
          end else begin
            angle <= '0;
            xv    <= xs;
            yv    <= ys;
          end
        end
      end
      C_NORM: begin
        iter <= '0;
        if (mx < BYTE_LIMIT) begin
          xv <= xv <<< 8;
          yv <= yv <<< 8;
        end else if (mx < NORM_LIMIT) begin
          xv <= xv <<< 1;
          yv <= yv <<< 1;
        end
      end
      C_ITER: begin
        if (!yv[CW-1]) begin
          xv    <= xv + dx;
          yv    <= yv - dy;
          angle <= angle + step_ang;
        end else begin
          xv    <= xv - dx;
          yv    <= yv + dy;
          angle <= angle - step_ang;
        end
        iter <= iter + IW'(1);
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

@@ test/tlik_checker.sv @@
// Checker for the three link leg IK block: watches the configuration port and both channels,
// predicts joint angles from its own copy of foot position and link registers, compares results.
// Depends on tlik_pkg for widths and register indexes.
`timescale 1ns / 1ps
module tlik_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [1:0]                          cfg_index,
  input  logic [tlik_pkg::LEN_W-1:0]          cfg_data,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic                                func,
  input  logic signed [tlik_pkg::COORD_W-1:0] coord_x,
  input  logic signed [tlik_pkg::COORD_W-1:0] coord_y,
  input  logic signed [tlik_pkg::COORD_W-1:0] coord_z,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic signed [tlik_pkg::OUT_W-1:0]   hip_angle,
  input  logic signed [tlik_pkg::OUT_W-1:0]   knee_angle,
  input  logic signed [tlik_pkg::OUT_W-1:0]   ankle_angle,
  input  logic                                out_of_reach,
  output int                                  fail_count,
  output int                                  pending
);
  import tlik_pkg::*;

  typedef struct packed {
    logic signed [OUT_W-1:0] hip;
    logic signed [OUT_W-1:0] knee;
    logic signed [OUT_W-1:0] ankle;
    logic                    reach;
  } angles_t;

  localparam longint PI29 = 64'sd1686629713;
  localparam longint NORM = 64'sd1 << 39;

  angles_t     angle_q[$];
  logic [13:0] hip_len, thigh_len, shin_len;
  logic        mirror;
  longint      px, py, pz;

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint arctan(longint yv, longint xv);
    longint ang, mx, ay, dx, dy;
    ang = 0;
    if (xv == 0 && yv == 0) return 0;
    if (xv < 0) begin
      ang = (yv >= 0) ? PI29 : -PI29;
      xv = -xv;
      yv = -yv;
    end
    ay = yv < 0 ? -yv : yv;
    mx = xv > ay ? xv : ay;
    while (mx < NORM) begin
      xv *= 2;
      yv *= 2;
      mx *= 2;
    end
    for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
      dx = yv >>> i;
      dy = xv >>> i;
      if (yv >= 0) begin
        xv += dx; yv -= dy; ang += longint'(atan_q29(5'(i)));
      end else begin
        xv -= dx; yv += dy; ang -= longint'(atan_q29(5'(i)));
      end
    end
    return ang;
  endfunction

  function automatic longint arccos(longint n, longint unsigned d2, ref logic flag);
    longint unsigned mag, n2;
    longint s;
    mag = n < 0 ? -n : n;
    n2 = mag * mag;
    s = 0;
    if (d2 == 0 || n2 > d2) flag = 1'b1;
    else s = longint'(root_floor(d2 - n2));
    return arctan(s, n);
  endfunction

  function automatic logic signed [OUT_W-1:0] to_q13(longint q29);
    longint t;
    t = (q29 + 32768) >>> 16;
    return t[OUT_W-1:0];
  endfunction

  function automatic longint clamp16(longint v);
    return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
  endfunction

  function automatic angles_t leg_angles(longint x, longint y, longint z);
    angles_t r;
    longint a, c2, m2, l2, hp, kn, an;
    logic flag;
    flag = 1'b0;
    a = longint'(root_floor(x * x + y * y)) - longint'(hip_len);
    c2 = a * a + z * z;
    m2 = longint'(thigh_len) * thigh_len;
    l2 = longint'(shin_len) * shin_len;
    hp = arctan(x, y);
    if (mirror) hp = -hp;
    kn = arccos(c2 + m2 - l2, 4 * c2 * m2, flag) - arctan(z, a);
    an = arccos(m2 + l2 - c2, 4 * m2 * l2, flag) - PI29;
    r.hip = to_q13(hp);
    r.knee = to_q13(kn);
    r.ankle = to_q13(an);
    r.reach = flag;
    return r;
  endfunction

  assign pending = angle_q.size();

  always @(posedge clk) begin
    angles_t e;
    if (rst) begin
      hip_len <= '0; thigh_len <= '0; shin_len <= '0; mirror <= 1'b0;
      px = 0; py = 0; pz = 0;
      fail_count <= 0;
      angle_q.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_HIP:    hip_len <= cfg_data;
          REG_THIGH:  thigh_len <= cfg_data;
          REG_SHIN:   shin_len <= cfg_data;
          REG_MIRROR: mirror <= cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (func) begin
          px = clamp16(px + coord_x);
          py = clamp16(py + coord_y);
          pz = clamp16(pz + coord_z);
        end else begin
          px = coord_x; py = coord_y; pz = coord_z;
        end
        angle_q.push_back(leg_angles(px, py, pz));
      end
      if (out_valid && out_ready) begin
        if (angle_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result transaction");
        end else begin
          e = angle_q.pop_front();
          if (e != {hip_angle, knee_angle, ankle_angle, out_of_reach}) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch: exp %0d %0d %0d %0b got %0d %0d %0d %0b",
                       e.hip, e.knee, e.ankle, e.reach,
                       hip_angle, knee_angle, ankle_angle, out_of_reach);
          end
        end
      end
    end
  end
endmodule

@@ test/tb_top.sv @@
// Testbench top for the three link leg IK block: clock, reset, configuration phases,
// directed and random stimulus, receiver stalls and the verdict. Depends on tlik_checker, tlik_pkg.
`timescale 1ns / 1ps
module tb_top;
  import tlik_pkg::*;

  logic clk = 0, rst = 1;
  logic cfg_write = 0;
  logic [1:0] cfg_index = REG_HIP;
  logic [LEN_W-1:0] cfg_data = '0;
  logic in_valid = 0, func = 0, out_ready = 0;
  logic signed [COORD_W-1:0] coord_x = '0, coord_y = '0, coord_z = '0;
  logic in_ready, out_valid, out_of_reach;
  logic signed [OUT_W-1:0] hip_angle, knee_angle, ankle_angle;
  int fail_count, pending, idle_cycles;

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  three_link_leg_inverse_kinematics dut (.*);
  tlik_checker chk (.*);

  // receiver stalls in phases: none, light, heavy
  always @(posedge clk) begin
    int ph;
    ph = int'(($time / 40000) % 3);
    if (rst) out_ready <= 1'b0;
    else if (ph == 0) out_ready <= 1'b1;
    else if (ph == 1) out_ready <= ($urandom_range(0, 3) != 0);
    else out_ready <= ($urandom_range(0, 3) == 0);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [LEN_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic push_target(logic f, logic [15:0] x, logic [15:0] y, logic [15:0] z);
    in_valid <= 1'b1;
    func <= f;
    coord_x <= x;
    coord_y <= y;
    coord_z <= z;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drain();
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic set_leg(logic [13:0] h, logic [13:0] m, logic [13:0] l, logic mr);
    reg_write(REG_HIP, h);
    reg_write(REG_THIGH, m);
    reg_write(REG_SHIN, l);
    reg_write(REG_MIRROR, LEN_W'(mr));
  endtask

  task automatic random_targets(int n, int scale);
    int burst;
    logic [15:0] r;
    while (n > 0) begin
      burst = $urandom_range(1, 8);
      while (burst > 0 && n > 0) begin
        if ($urandom_range(0, 3) == 0) begin
          r = 16'($urandom_range(0, 2047) - 1024);
          push_target(1'b1, $urandom_range(0, 9) == 0 ? 16'($urandom) : r,
                      16'($urandom_range(0, 2047) - 1024), 16'($urandom_range(0, 2047) - 1024));
        end else if (scale == 0) begin
          push_target(1'b0, 16'($urandom), 16'($urandom), 16'($urandom));
        end else begin
          push_target(1'b0, 16'($urandom_range(0, 2 * scale) - scale),
                      16'($urandom_range(0, 2 * scale) - scale),
                      16'($urandom_range(0, 2 * scale) - scale));
        end
        burst--;
        n--;
      end
      if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 300)) @(posedge clk);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // default registers: zero links
    push_target(1'b0, 16'd0, 16'd0, 16'd0);
    push_target(1'b0, 16'h7fff, 16'h7fff, 16'h7fff);
    wait_drain();
    set_leg(14'd600, 14'd1600, 14'd1800, 1'b0);
    push_target(1'b0, 16'd0, 16'd0, 16'd0);
    push_target(1'b0, 16'h8000, 16'h8000, 16'h8000);
    push_target(1'b0, 16'h7fff, 16'h8000, 16'h7fff);
    push_target(1'b0, 16'd100, 16'h8000, 16'd0);
    push_target(1'b0, 16'd0, 16'hfc00, 16'd0);
    push_target(1'b0, 16'd0, 16'd2000, 16'hf000);
    push_target(1'b0, 16'd600, 16'd0, 16'd0);
    push_target(1'b1, 16'h7fff, 16'h7fff, 16'h7fff);
    push_target(1'b1, 16'h7fff, 16'h7fff, 16'h7fff);
    push_target(1'b0, 16'h8000, 16'h8000, 16'h8000);
    push_target(1'b1, 16'h8000, 16'h8000, 16'h8000);
    push_target(1'b0, 16'd1000, 16'd1500, 16'hfa00);
    push_target(1'b1, 16'd5, 16'hfffb, 16'd3);
    wait_drain();
    set_leg(14'h3fff, 14'h3fff, 14'h3fff, 1'b1);
    push_target(1'b0, 16'd100, 16'd200, 16'd300);
    push_target(1'b0, 16'h7fff, 16'h7fff, 16'h8000);
    push_target(1'b0, 16'h8000, 16'd0, 16'd0);
    random_targets(200, 0);
    wait_drain();
    set_leg(14'd700, 14'd2000, 14'd2400, 1'b1);
    random_targets(700, 3500);
    wait_drain();
    set_leg(14'd0, 14'd1000, 14'd1000, 1'b0);
    random_targets(300, 2500);
    wait_drain();
    set_leg(14'($urandom), 14'($urandom), 14'($urandom), 1'($urandom));
    random_targets(300, 0);
    wait_drain();
    set_leg(14'd500, 14'd3000, 14'd3000, 1'b0);
    random_targets(300, 7000);
    wait_drain();
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
